### hw/rtl/npq_pkg.sv
// Shared types and constants for the nearest point and radius query block.
package npq_pkg;

   localparam int DIM        = 7;
   localparam int COORD_BITS = 24;
   localparam int LABEL_W    = 16;
   localparam int SLOT_W     = 10;
   localparam int COUNT_W    = 11;
   localparam int RADIUS_W   = 27;
   localparam int DIST_W     = 27;
   localparam int CSR_IDX_W  = 2;

   localparam int DIFF_W  = COORD_BITS + 1;
   localparam int SQ_W    = 2 * DIFF_W;
   localparam int LANES   = 8;
   localparam int PAIRS   = LANES / 2;
   localparam int D2_W    = SQ_W + 3;
   localparam int R2_W    = 2 * RADIUS_W;
   localparam int ROOT_W  = D2_W + (D2_W % 2);
   localparam int NSTAGE  = 5;
   localparam int POINT_W = DIM * COORD_BITS;

   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS      = 2'd1;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef struct packed {
      logic load_write;
      logic query_start;
      logic scan_en;
      logic root_start;
      logic root_step;
      logic out_load;
   } npq_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic pipe_empty;
      logic root_done;
      logic out_free;
   } npq_status_type;

endpackage

### hw/rtl/npq_ctrl.sv
// Sequencer for loads, the table scan, the square root and the result hand-off.
module npq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_mode,
   output logic                   req_ready,
   input  npq_pkg::npq_status_type status,
   output npq_pkg::npq_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_ROOT   = 3'd2;
   localparam logic [2:0] ST_FINISH = 3'd3;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       req_beat;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_beat  = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load_write  = req_beat && (req_mode == npq_pkg::MODE_LOAD);
            cmd.query_start = req_beat && (req_mode == npq_pkg::MODE_QUERY);
            if (cmd.query_start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_en = 1'b1;
            if (status.scan_done && status.pipe_empty) begin
               cmd.root_start = 1'b1;
               state_in       = ST_ROOT;
            end
         end
         ST_ROOT: begin
            cmd.root_step = !status.root_done;
            if (status.root_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/npq_dp.sv
// Datapath: point table, distance pipeline, best and hit tracking, square root, result register.
module npq_dp #(
   parameter int MAX_POINTS = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  npq_pkg::npq_cmd_type                   cmd,
   output npq_pkg::npq_status_type                status,
   input  logic                                  csr_valid,
   input  logic [npq_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [npq_pkg::RADIUS_W-1:0]          csr_wdata,
   input  logic [npq_pkg::SLOT_W-1:0]            req_slot,
   input  logic [npq_pkg::LABEL_W-1:0]           req_label,
   input  logic [npq_pkg::POINT_W-1:0]           req_point,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic                                  rsp_found_any,
   output logic [npq_pkg::LABEL_W-1:0]           rsp_nearest_label,
   output logic [npq_pkg::DIST_W-1:0]            rsp_nearest_distance,
   output logic                                  rsp_hit_found,
   output logic [npq_pkg::SLOT_W-1:0]            rsp_hit_slot
);

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int CB = npq_pkg::COORD_BITS;
   localparam int NS = npq_pkg::NSTAGE;

   // configuration registers
   logic [npq_pkg::COUNT_W-1:0]  point_count_ff;
   logic [npq_pkg::RADIUS_W-1:0] radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= '0;
         radius_ff      <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            npq_pkg::CSR_POINT_COUNT: point_count_ff <= csr_wdata[npq_pkg::COUNT_W-1:0];
            npq_pkg::CSR_RADIUS:      radius_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // point table, one row per entry
   logic [npq_pkg::POINT_W-1:0] coord_mem [MAX_POINTS];
   logic [npq_pkg::LABEL_W-1:0] label_mem [MAX_POINTS];
   logic                        slot_in_range;
   logic [AW-1:0]               wr_addr;

   assign slot_in_range = (32'(req_slot) < MAX_POINTS);
   assign wr_addr       = AW'(req_slot);

   // query latches and scan counter
   logic [npq_pkg::POINT_W-1:0] query_ff;
   logic [npq_pkg::R2_W-1:0]    r2_ff;
   logic [CW-1:0]               count_ff;
   logic [CW-1:0]               count_in;
   logic [CW-1:0]               idx_ff;
   logic                        issue;

   assign count_in = (32'(point_count_ff) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(point_count_ff);
   assign issue    = cmd.scan_en && (idx_ff < count_ff);

   always_ff @(posedge clock) begin
      if (cmd.query_start) begin
         query_ff <= req_point;
         r2_ff    <= npq_pkg::R2_W'(radius_ff) * npq_pkg::R2_W'(radius_ff);
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.query_start) begin
         idx_ff <= '0;
      end else if (issue) begin
         idx_ff <= idx_ff + CW'(1);
      end
   end

   // pipeline bookkeeping: valid, slot and label per stage
   logic [NS-1:0]               valid_ff;
   logic [AW-1:0]               pidx_ff [NS];
   logic [npq_pkg::LABEL_W-1:0] plab_ff [1:NS-1];
   logic [npq_pkg::LABEL_W-1:0] rd_label_ff;
   logic [npq_pkg::POINT_W-1:0] rd_point_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_write && slot_in_range) begin
         coord_mem[wr_addr] <= req_point;
      end
      if (issue) begin
         rd_point_ff <= coord_mem[idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_write && slot_in_range) begin
         label_mem[wr_addr] <= req_label;
      end
      if (issue) begin
         rd_label_ff <= label_mem[idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[NS-2:0], issue};
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff[0] <= idx_ff[AW-1:0];
      plab_ff[1] <= rd_label_ff;
      for (int s = 1; s < NS; s++) begin
         pidx_ff[s] <= pidx_ff[s-1];
      end
      for (int s = 2; s < NS; s++) begin
         plab_ff[s] <= plab_ff[s-1];
      end
   end

   // stage 2: absolute differences, stage 3: squares
   logic [npq_pkg::DIFF_W-1:0] absd_ff [npq_pkg::LANES];
   logic [npq_pkg::SQ_W-1:0]   sq_ff   [npq_pkg::LANES];

   for (genvar d = 0; d < npq_pkg::LANES; d++) begin : g_lane
      if (d < npq_pkg::DIM) begin : g_used
         logic signed [npq_pkg::DIFF_W-1:0] diff;
         assign diff = npq_pkg::DIFF_W'($signed(rd_point_ff[d*CB +: CB]))
                     - npq_pkg::DIFF_W'($signed(query_ff[d*CB +: CB]));
         always_ff @(posedge clock) begin
            absd_ff[d] <= diff[npq_pkg::DIFF_W-1] ? npq_pkg::DIFF_W'(-diff)
                                                  : npq_pkg::DIFF_W'(diff);
         end
      end else begin : g_pad
         always_ff @(posedge clock) begin
            absd_ff[d] <= '0;
         end
      end
      always_ff @(posedge clock) begin
         sq_ff[d] <= npq_pkg::SQ_W'(absd_ff[d]) * npq_pkg::SQ_W'(absd_ff[d]);
      end
   end

   // stage 4: pair sums, stage 5: total
   logic [npq_pkg::D2_W-1:0] pair_ff [npq_pkg::PAIRS];
   logic [npq_pkg::D2_W-1:0] total_ff;

   always_ff @(posedge clock) begin
      for (int p = 0; p < npq_pkg::PAIRS; p++) begin
         pair_ff[p] <= npq_pkg::D2_W'(sq_ff[2*p]) + npq_pkg::D2_W'(sq_ff[2*p+1]);
      end
      total_ff <= (pair_ff[0] + pair_ff[1]) + (pair_ff[2] + pair_ff[3]);
   end

   // best and first hit
   logic                        found_ff;
   logic [npq_pkg::D2_W-1:0]    best_ff;
   logic [npq_pkg::LABEL_W-1:0] best_label_ff;
   logic                        hit_ff;
   logic [npq_pkg::SLOT_W-1:0]  hit_slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else if (cmd.query_start) begin
         found_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else if (valid_ff[NS-1]) begin
         if (!found_ff || total_ff < best_ff) begin
            found_ff <= 1'b1;
         end
         if (!hit_ff && npq_pkg::R2_W'(total_ff) < r2_ff) begin
            hit_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.query_start) begin
         best_ff       <= '0;
         best_label_ff <= '0;
         hit_slot_ff   <= '0;
      end else if (valid_ff[NS-1]) begin
         if (!found_ff || total_ff < best_ff) begin
            best_ff       <= total_ff;
            best_label_ff <= plab_ff[NS-1];
         end
         if (!hit_ff && npq_pkg::R2_W'(total_ff) < r2_ff) begin
            hit_slot_ff <= npq_pkg::SLOT_W'(pidx_ff[NS-1]);
         end
      end
   end

   // digit-by-digit square root, one result bit from two bits of the radicand per step
   logic [npq_pkg::ROOT_W-1:0] rem_ff;
   logic [npq_pkg::ROOT_W-1:0] res_ff;
   logic [npq_pkg::ROOT_W-1:0] bit_ff;
   logic [npq_pkg::ROOT_W-1:0] trial;

   assign trial = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= '0;
      end else if (cmd.root_start) begin
         bit_ff <= npq_pkg::ROOT_W'(1) << (npq_pkg::ROOT_W - 2);
      end else if (cmd.root_step) begin
         bit_ff <= bit_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.root_start) begin
         rem_ff <= npq_pkg::ROOT_W'(best_ff);
         res_ff <= '0;
      end else if (cmd.root_step) begin
         if (rem_ff >= trial) begin
            rem_ff <= rem_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
      end
   end

   // result register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_found_any        <= found_ff;
         rsp_nearest_label    <= best_label_ff;
         rsp_nearest_distance <= npq_pkg::DIST_W'(res_ff);
         rsp_hit_found        <= hit_ff;
         rsp_hit_slot         <= hit_slot_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign status.scan_done  = (idx_ff == count_ff);
   assign status.pipe_empty = (valid_ff == '0);
   assign status.root_done  = (bit_ff == '0);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

endmodule

### hw/rtl/nearest_point_and_radius_query.sv
// Query n = min(point_count, MAX_POINTS) entries: the scan reads one table row per cycle,
// then a five stage distance pipeline drains and the square root runs 27 iterations.
// A load beat gives no result. The next beat is taken as soon as the result sits in the
// output register. Reset clears control and the configuration registers; the point
// table holds whatever was last written.
module nearest_point_and_radius_query #(
   parameter int MAX_POINTS = 1024
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [npq_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [npq_pkg::RADIUS_W-1:0]           csr_wdata,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_mode,
   input  logic [npq_pkg::SLOT_W-1:0]             req_slot,
   input  logic [npq_pkg::LABEL_W-1:0]            req_label,
   input  logic signed [npq_pkg::COORD_BITS-1:0]  req_coord_0,
   input  logic signed [npq_pkg::COORD_BITS-1:0]  req_coord_1,
   input  logic signed [npq_pkg::COORD_BITS-1:0]  req_coord_2,
   input  logic signed [npq_pkg::COORD_BITS-1:0]  req_coord_3,
   input  logic signed [npq_pkg::COORD_BITS-1:0]  req_coord_4,
   input  logic signed [npq_pkg::COORD_BITS-1:0]  req_coord_5,
   input  logic signed [npq_pkg::COORD_BITS-1:0]  req_coord_6,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_found_any,
   output logic [npq_pkg::LABEL_W-1:0]            rsp_nearest_label,
   output logic [npq_pkg::DIST_W-1:0]             rsp_nearest_distance,
   output logic                                   rsp_hit_found,
   output logic [npq_pkg::SLOT_W-1:0]             rsp_hit_slot
);

   npq_pkg::npq_cmd_type        cmd;
   npq_pkg::npq_status_type     status;
   logic [npq_pkg::POINT_W-1:0] req_point;

   assign csr_ready = 1'b1;
   assign req_point = {req_coord_6, req_coord_5, req_coord_4, req_coord_3,
                       req_coord_2, req_coord_1, req_coord_0};

   npq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   npq_dp #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .csr_valid            (csr_valid),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_slot             (req_slot),
      .req_label            (req_label),
      .req_point            (req_point),
      .rsp_ready            (rsp_ready),
      .rsp_valid            (rsp_valid),
      .rsp_found_any        (rsp_found_any),
      .rsp_nearest_label    (rsp_nearest_label),
      .rsp_nearest_distance (rsp_nearest_distance),
      .rsp_hit_found        (rsp_hit_found),
      .rsp_hit_slot         (rsp_hit_slot)
   );

endmodule

### sim/tb_nearest_point_and_radius_query.sv
// Self-checking testbench for the nearest point and radius query block.
module tb_nearest_point_and_radius_query;

   localparam int TABLE_DEPTH   = 1024;
   localparam int HOLD_CYCLES   = 2000;
   localparam int QUIET_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 40;
   localparam int TAIL_CYCLES   = 1100;
   localparam int RAND_PHASES   = 12;
   localparam int PHASE_BEATS   = 46;
   localparam int C_HI          = 8388607;
   localparam int C_LO          = -8388608;

   localparam logic [npq_pkg::CSR_IDX_W-1:0]  CSR_SPARE_A = 2'd2;
   localparam logic [npq_pkg::CSR_IDX_W-1:0]  CSR_SPARE_B = 2'd3;
   localparam logic [npq_pkg::COORD_BITS-1:0] C_MAX       = 24'h7F_FFFF;
   localparam logic [npq_pkg::COORD_BITS-1:0] C_MIN       = 24'h80_0000;
   localparam longint unsigned                DIST_CEIL   = 64'h7FF_FFFF;

   typedef logic [npq_pkg::DIM-1:0][npq_pkg::COORD_BITS-1:0] coord_vec_type;

   typedef struct packed {
      logic                        mode;
      logic [npq_pkg::SLOT_W-1:0]  slot;
      logic [npq_pkg::LABEL_W-1:0] label;
      coord_vec_type               coords;
   } point_beat_type;

   typedef struct packed {
      logic                        found;
      logic [npq_pkg::LABEL_W-1:0] label;
      logic [npq_pkg::DIST_W-1:0]  near_dist;
      logic                        hit;
      logic [npq_pkg::SLOT_W-1:0]  slot;
   } query_answer_type;

   typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [npq_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [npq_pkg::RADIUS_W-1:0]  csr_wdata = '0;

   point_beat_type drv = '0;
   logic           req_valid = 1'b0;
   logic           req_ready;
   logic           req_mode;
   logic [npq_pkg::SLOT_W-1:0]  req_slot;
   logic [npq_pkg::LABEL_W-1:0] req_label;
   logic signed [npq_pkg::COORD_BITS-1:0] req_coord_0, req_coord_1, req_coord_2, req_coord_3;
   logic signed [npq_pkg::COORD_BITS-1:0] req_coord_4, req_coord_5, req_coord_6;

   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic                        rsp_found_any;
   logic [npq_pkg::LABEL_W-1:0] rsp_nearest_label;
   logic [npq_pkg::DIST_W-1:0]  rsp_nearest_distance;
   logic                        rsp_hit_found;
   logic [npq_pkg::SLOT_W-1:0]  rsp_hit_slot;

   assign req_mode    = drv.mode;
   assign req_slot    = drv.slot;
   assign req_label   = drv.label;
   assign req_coord_0 = drv.coords[0];
   assign req_coord_1 = drv.coords[1];
   assign req_coord_2 = drv.coords[2];
   assign req_coord_3 = drv.coords[3];
   assign req_coord_4 = drv.coords[4];
   assign req_coord_5 = drv.coords[5];
   assign req_coord_6 = drv.coords[6];

   nearest_point_and_radius_query #(.MAX_POINTS(TABLE_DEPTH)) u_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mode             (req_mode),
      .req_slot             (req_slot),
      .req_label            (req_label),
      .req_coord_0          (req_coord_0),
      .req_coord_1          (req_coord_1),
      .req_coord_2          (req_coord_2),
      .req_coord_3          (req_coord_3),
      .req_coord_4          (req_coord_4),
      .req_coord_5          (req_coord_5),
      .req_coord_6          (req_coord_6),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_found_any        (rsp_found_any),
      .rsp_nearest_label    (rsp_nearest_label),
      .rsp_nearest_distance (rsp_nearest_distance),
      .rsp_hit_found        (rsp_hit_found),
      .rsp_hit_slot         (rsp_hit_slot)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------- predictor state ----------------
   coord_vec_type               tbl_pts   [TABLE_DEPTH];
   logic [npq_pkg::LABEL_W-1:0] tbl_label [TABLE_DEPTH];
   logic [npq_pkg::COUNT_W-1:0]  cfg_count  = '0;
   logic [npq_pkg::RADIUS_W-1:0] cfg_radius = '0;

   query_answer_type answers_due [$];
   query_answer_type want_ans;
   point_beat_type   pending [$];
   int               mismatch_count = 0;

   // ---------------- stimulus bookkeeping ----------------
   coord_vec_type stim_pts     [TABLE_DEPTH];
   bit            stim_written [TABLE_DEPTH];
   int            stim_prefix = 0;
   coord_vec_type centers [4];

   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned r, t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   function automatic query_answer_type search_table(input coord_vec_type q);
      query_answer_type a;
      longint unsigned  d2, best, r2, sq, root;
      longint           dlt;
      int               n;
      a = '0;
      best = 0;
      n = (cfg_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(cfg_count);
      r2 = cfg_radius;
      r2 = r2 * r2;
      for (int j = 0; j < n; j++) begin
         d2 = 0;
         for (int d = 0; d < npq_pkg::DIM; d++) begin
            dlt = longint'($signed(tbl_pts[j][d])) - longint'($signed(q[d]));
            sq = longint'(dlt * dlt);
            if (d2 > 64'hFFFF_FFFF_FFFF_FFFF - sq) d2 = 64'hFFFF_FFFF_FFFF_FFFF;
            else d2 = d2 + sq;
         end
         if (j == 0 || d2 < best) begin
            best = d2;
            a.label = tbl_label[j];
         end
         if (!a.hit && d2 < r2) begin
            a.hit = 1'b1;
            a.slot = npq_pkg::SLOT_W'(j);
         end
      end
      if (n > 0) begin
         a.found = 1'b1;
         root = floor_root(best);
         a.near_dist = npq_pkg::DIST_W'((root > DIST_CEIL) ? DIST_CEIL : root);
      end
      return a;
   endfunction

   function automatic void check_field(input string fname, input longint unsigned want,
                                       input longint unsigned got);
      if (want != got) begin
         $display("%0t: %s expected 0x%0h actual 0x%0h", $time, fname, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic coord_vec_type rand_point();
      coord_vec_type p;
      for (int d = 0; d < npq_pkg::DIM; d++) p[d] = npq_pkg::COORD_BITS'($urandom());
      return p;
   endfunction

   // random offset of up to +/- 2^span_log2 per axis, clamped to the coordinate range
   function automatic coord_vec_type jitter(input coord_vec_type base, input int span_log2);
      coord_vec_type p;
      int            v;
      for (int d = 0; d < npq_pkg::DIM; d++) begin
         v = int'($signed(base[d])) + int'($urandom_range(0, 2 << span_log2))
             - (1 << span_log2);
         if (v > C_HI) v = C_HI;
         else if (v < C_LO) v = C_LO;
         p[d] = npq_pkg::COORD_BITS'(v);
      end
      return p;
   endfunction

   function automatic void push_load(input int s, input logic [npq_pkg::LABEL_W-1:0] lbl,
                                     input coord_vec_type pt);
      point_beat_type b;
      b.mode   = npq_pkg::MODE_LOAD;
      b.slot   = npq_pkg::SLOT_W'(s);
      b.label  = lbl;
      b.coords = pt;
      pending = {pending, b};
      stim_pts[s] = pt;
      stim_written[s] = 1'b1;
      while (stim_prefix < TABLE_DEPTH && stim_written[stim_prefix]) stim_prefix++;
   endfunction

   function automatic void push_query(input coord_vec_type pt);
      point_beat_type b;
      b.mode   = npq_pkg::MODE_QUERY;
      b.slot   = npq_pkg::SLOT_W'($urandom());
      b.label  = npq_pkg::LABEL_W'($urandom());
      b.coords = pt;
      pending = {pending, b};
   endfunction

   function automatic coord_vec_type some_stored_point();
      return stim_pts[$urandom_range(0, stim_prefix - 1)];
   endfunction

   task automatic csr_write(input logic [npq_pkg::CSR_IDX_W-1:0] idx,
                            input logic [npq_pkg::RADIUS_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // upper bits of the write are junk; only the low COUNT_W bits land
   task automatic set_count(input int cnt);
      logic [npq_pkg::RADIUS_W-1:0] w;
      w = npq_pkg::RADIUS_W'($urandom());
      w[npq_pkg::COUNT_W-1:0] = npq_pkg::COUNT_W'(cnt);
      csr_write(npq_pkg::CSR_POINT_COUNT, w);
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending.size() != 0 || req_valid || answers_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------- request driver ----------------
   int burst_left = 1;
   int gap_left   = 0;
   int gap_pick;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = $urandom_range(1, 16);
         gap_left = 0;
      end else if (!req_valid || req_ready) begin
         if (gap_left != 0 || pending.size() == 0) begin
            if (gap_left != 0) gap_left--;
            req_valid <= 1'b0;
         end else begin
            drv <= pending.pop_front();
            req_valid <= 1'b1;
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_pick = $urandom_range(0, 9);
               if (gap_pick < 3) gap_left = 0;
               else if (gap_pick < 9) gap_left = $urandom_range(1, 8);
               else gap_left = $urandom_range(20, 60);
            end
         end
      end
   end

   // ---------------- predictor: config and request beats ----------------
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               npq_pkg::CSR_POINT_COUNT: cfg_count = csr_wdata[npq_pkg::COUNT_W-1:0];
               npq_pkg::CSR_RADIUS:      cfg_radius = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (drv.mode == npq_pkg::MODE_LOAD) begin
               tbl_pts[drv.slot] = drv.coords;
               tbl_label[drv.slot] = drv.label;
            end else begin
               answers_due = {answers_due, search_table(drv.coords)};
            end
         end
      end
   end

   // ---------------- result receiver ----------------
   rx_style_type rx_style = RX_OPEN;
   int           style_left   = 0;
   int           stall_period = 3;
   int           hold_left    = 0;
   int           rsp_taken    = 0;
   int           rx_cycle     = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
         rsp_taken = 0;
         style_left = 0;
      end else begin
         rx_cycle++;
         if (rsp_valid && rsp_ready) rsp_taken++;
         if (style_left == 0) begin
            rx_style = rx_style_type'($urandom_range(0, 2));
            style_left = $urandom_range(16, 160);
            stall_period = $urandom_range(2, 7);
         end else begin
            style_left--;
         end
         // long backpressure so the block fills and stalls its request side
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_valid && rsp_ready && (rsp_taken == 40 || rsp_taken == 200)) begin
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            case (rx_style)
               RX_OPEN:   rsp_ready <= 1'b1;
               RX_RANDOM: rsp_ready <= ($urandom_range(0, 3) != 0);
               default:   rsp_ready <= ((rx_cycle % stall_period) != 0);
            endcase
         end
      end
   end

   // ---------------- result checker ----------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (answers_due.size() == 0) begin
            $display("%0t: result beat with nothing awaited, expected none actual label 0x%0h",
                     $time, rsp_nearest_label);
            mismatch_count++;
         end else begin
            want_ans = answers_due.pop_front();
            check_field("found_any", want_ans.found, rsp_found_any);
            check_field("nearest_label", want_ans.label, rsp_nearest_label);
            check_field("nearest_distance", want_ans.near_dist, rsp_nearest_distance);
            check_field("hit_found", want_ans.hit, rsp_hit_found);
            check_field("hit_slot", want_ans.slot, rsp_hit_slot);
         end
      end
   end

   // ---------------- watchdog ----------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------- stimulus ----------------
   initial begin
      coord_vec_type                q, alt;
      int                           pick, k, s, cnt;
      logic [npq_pkg::RADIUS_W-1:0] rad;

      for (int d = 0; d < npq_pkg::DIM; d++) alt[d] = d[0] ? C_MIN : C_MAX;
      for (int c = 0; c < 4; c++) centers[c] = rand_point();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty table scan right after reset
      push_query({npq_pkg::DIM{C_MAX}});
      push_load(0, 16'hFFFF, {npq_pkg::DIM{C_MAX}});
      push_load(1, 16'h0000, {npq_pkg::DIM{C_MIN}});
      push_load(2, 16'h1234, '0);
      push_load(3, 16'hBEEF, '0);   // duplicate of slot 2, first one wins the tie
      push_load(4, 16'hA5A5, alt);
      push_load(5, npq_pkg::LABEL_W'($urandom()), rand_point());
      push_load(TABLE_DEPTH - 1, 16'h5A5A, ~alt);
      wait_drained();

      set_count(6);
      csr_write(npq_pkg::CSR_RADIUS, '0);
      push_query('0);
      push_query({npq_pkg::DIM{C_MAX}});
      push_query({npq_pkg::DIM{C_MIN}});
      push_query(~alt);
      wait_drained();

      csr_write(npq_pkg::CSR_RADIUS, '1);
      csr_write(CSR_SPARE_A, npq_pkg::RADIUS_W'($urandom()));
      csr_write(CSR_SPARE_B, npq_pkg::RADIUS_W'($urandom()));
      push_query('0);
      push_query({npq_pkg::DIM{C_MAX}});
      wait_drained();

      // radius of one lsb: only an exact match hits
      csr_write(npq_pkg::CSR_RADIUS, npq_pkg::RADIUS_W'(1));
      push_query('0);
      q = {npq_pkg::DIM{C_MIN}};
      q[3] = C_MIN + 1'b1;
      push_query(q);
      wait_drained();

      set_count(1);
      push_query('0);
      wait_drained();

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) cnt = 0;
         else if (pick < 7) cnt = $urandom_range(1, (stim_prefix < 40) ? stim_prefix : 40);
         else cnt = stim_prefix;
         k = $urandom_range(0, npq_pkg::RADIUS_W);
         if (k == 0) rad = '0;
         else if (k == npq_pkg::RADIUS_W) rad = '1;
         else rad = npq_pkg::RADIUS_W'($urandom_range(0, (1 << k) - 1));
         if ($urandom_range(0, 1) == 0) begin
            set_count(cnt);
            csr_write(npq_pkg::CSR_RADIUS, rad);
         end else begin
            csr_write(npq_pkg::CSR_RADIUS, rad);
            set_count(cnt);
         end
         if ($urandom_range(0, 2) == 0)
            csr_write($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B,
                      npq_pkg::RADIUS_W'($urandom()));

         repeat (PHASE_BEATS) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               k = $urandom_range(0, 9);
               if (k < 6 && stim_prefix < TABLE_DEPTH) s = stim_prefix;
               else if (k < 8) s = $urandom_range(0, stim_prefix - 1);
               else s = $urandom_range(0, TABLE_DEPTH - 1);
               k = $urandom_range(0, 9);
               if (k < 6) q = jitter(centers[$urandom_range(0, 3)], $urandom_range(2, 18));
               else if (k < 8) q = some_stored_point();
               else q = rand_point();
               push_load(s, npq_pkg::LABEL_W'($urandom()), q);
            end else begin
               k = $urandom_range(0, 9);
               if (k < 5) q = jitter(some_stored_point(), $urandom_range(0, 18));
               else if (k < 7) q = jitter(centers[$urandom_range(0, 3)], $urandom_range(4, 20));
               else if (k < 9) q = rand_point();
               else q = some_stored_point();
               push_query(q);
            end
         end
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/npq_pkg.sv
hw/rtl/npq_ctrl.sv
hw/rtl/npq_dp.sv
hw/rtl/nearest_point_and_radius_query.sv
sim/tb_nearest_point_and_radius_query.sv
